@@ hdl/spike_rejecting_moving_average_core_defines.svh @@
// assertion macros shared by the spike-rejecting moving average core
`ifndef SPIKE_REJECTING_MOVING_AVERAGE_CORE_DEFINES_SVH
`define SPIKE_REJECTING_MOVING_AVERAGE_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define SRMA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SRMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/srma_pkg.sv @@
// package: shared types and constants of the spike-rejecting moving average core
package srma_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned HELD_W = 6;
   localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'h0001_0000;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EVICT,
      ST_INSERT,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_sample;
      logic check;
      logic evict;
      logic insert;
      logic div_start;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ hdl/srma_dp.sv @@
// datapath: window memory, running sum, fill count, serial divider and result register
`include "spike_rejecting_moving_average_core_defines.svh"

module srma_dp #(
   parameter int unsigned WINDOW_DEPTH = 50
) (
   input  logic                             clock,
   input  logic                             reset,
   input  srma_pkg::ctrl_cmd_type           cmd,
   output srma_pkg::dp_status_type          status,
   input  logic [srma_pkg::DATA_W-1:0]      req_interval_sample,
   input  logic                             csr_write,
   input  logic [srma_pkg::DATA_W-1:0]      csr_reject_threshold,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [srma_pkg::DATA_W-1:0]      rsp_smoothed_interval,
   output logic                             rsp_sample_accepted,
   output logic [srma_pkg::HELD_W-1:0]      rsp_samples_held
);

   localparam int unsigned DW       = srma_pkg::DATA_W;
   localparam int unsigned CNT_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned PTR_W    = $clog2(WINDOW_DEPTH);
   localparam int unsigned SUM_W    = DW + CNT_W;
   localparam int unsigned DCNT_W   = $clog2(SUM_W);
   localparam int unsigned HELD_EXT = srma_pkg::HELD_W;

   // window storage, read once per item and written only for an accepted sample
   logic [DW-1:0]     mem_ff [WINDOW_DEPTH];
   logic [DW-1:0]     rd_data_ff;

   logic [DW-1:0]     sample_ff;
   logic              accept_ff, accept_in;
   logic [DW-1:0]     threshold_ff, threshold_in;
   logic [DW-1:0]     last_avg_ff, last_avg_in;
   logic [CNT_W-1:0]  fill_count_ff, fill_count_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]     rsp_avg_ff;
   logic              rsp_acc_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;

   logic              full;
   logic [DW-1:0]     diff;
   logic [CNT_W:0]    trial;
   logic              trial_ge;
   logic [DW-1:0]     avg;
   logic [CNT_W+HELD_EXT-1:0] held_ext;

   assign full = (fill_count_ff == CNT_W'(WINDOW_DEPTH));

   // deviation from last average
   assign diff = (sample_ff >= last_avg_ff) ? (sample_ff - last_avg_ff)
                                            : (last_avg_ff - sample_ff);

   // one restoring division step
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, fill_count_ff});

   // mean of stored samples, zero while the window is empty
   assign avg = (fill_count_ff == '0) ? '0 : quo_ff[DW-1:0];

   // next-value logic for control registers
   always_comb begin
      threshold_in  = threshold_ff;
      accept_in     = accept_ff;
      last_avg_in   = last_avg_ff;
      fill_count_in = fill_count_ff;
      ptr_in        = ptr_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         threshold_in = csr_reject_threshold;
      end
      if (cmd.check) begin
         accept_in = (diff < threshold_ff);
      end
      if (cmd.evict && accept_ff && full) begin
         sum_in = sum_ff - {{CNT_W{1'b0}}, rd_data_ff};
      end
      if (cmd.insert && accept_ff) begin
         sum_in = sum_ff + {{CNT_W{1'b0}}, sample_ff};
         ptr_in = (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         if (!full) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
      if (cmd.div_start) begin
         rem_in     = '0;
         quo_in     = sum_ff;
         div_cnt_in = DCNT_W'(SUM_W - 1);
      end
      if (cmd.div_step) begin
         rem_in     = trial_ge ? CNT_W'(trial - {1'b0, fill_count_ff}) : trial[CNT_W-1:0];
         quo_in     = {quo_ff[SUM_W-2:0], trial_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         last_avg_in  = avg;
         rsp_valid_in = 1'b1;
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= srma_pkg::THRESHOLD_RESET;
         last_avg_ff   <= '0;
         fill_count_ff <= '0;
         ptr_ff        <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         threshold_ff  <= threshold_in;
         last_avg_ff   <= last_avg_in;
         fill_count_ff <= fill_count_in;
         ptr_ff        <= ptr_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      accept_ff  <= accept_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      if (cmd.load_sample) begin
         sample_ff <= req_interval_sample;
      end
      if (cmd.out_load) begin
         rsp_avg_ff <= avg;
         rsp_acc_ff <= accept_ff;
         rsp_cnt_ff <= fill_count_ff;
      end
   end

   // window memory: oldest slot read during check, accepted sample written on insert
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         rd_data_ff <= mem_ff[ptr_ff];
      end
      if (cmd.insert && accept_ff) begin
         mem_ff[ptr_ff] <= sample_ff;
      end
   end

   assign held_ext = {{HELD_EXT{1'b0}}, rsp_cnt_ff};

   assign status.div_last = (div_cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_smoothed_interval = rsp_avg_ff;
   assign rsp_sample_accepted   = rsp_acc_ff;
   assign rsp_samples_held      = held_ext[HELD_EXT-1:0];

   // fill count never passes the window depth
   `SRMA_ASSERT_HOLDS(a_count_bound, clock, reset, fill_count_ff <= CNT_W'(WINDOW_DEPTH), "fill count beyond window depth")
   // while filling, the write slot follows the fill count
   `SRMA_ASSERT_HOLDS(a_ptr_tracks_count, clock, reset, full || (CNT_W'(ptr_ff) == fill_count_ff), "write slot out of step with fill count")
   // an empty window holds a zero sum
   `SRMA_ASSERT_HOLDS(a_empty_sum, clock, reset, (fill_count_ff != '0) || (sum_ff == '0), "nonzero sum with empty window")
   // the fill count moves only on an insert
   `SRMA_ASSERT_NEXT(a_count_stable, clock, reset, !cmd.insert, $stable(fill_count_ff), "fill count changed outside insert")

endmodule

@@ hdl/srma_ctrl.sv @@
// controller: state machine sequencing check, window update, division and result load
module srma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  srma_pkg::dp_status_type status,
   output srma_pkg::ctrl_cmd_type  cmd
);

   srma_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srma_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = srma_pkg::ST_CHECK;
            end
         end
         srma_pkg::ST_CHECK:    state_in = srma_pkg::ST_EVICT;
         srma_pkg::ST_EVICT:    state_in = srma_pkg::ST_INSERT;
         srma_pkg::ST_INSERT:   state_in = srma_pkg::ST_DIV_LOAD;
         srma_pkg::ST_DIV_LOAD: state_in = srma_pkg::ST_DIVIDE;
         srma_pkg::ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = srma_pkg::ST_FINISH;
            end
         end
         srma_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = srma_pkg::ST_IDLE;
            end
         end
         default: state_in = srma_pkg::ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         srma_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.load_sample = req_valid;
         end
         srma_pkg::ST_CHECK:    cmd.check     = 1'b1;
         srma_pkg::ST_EVICT:    cmd.evict     = 1'b1;
         srma_pkg::ST_INSERT:   cmd.insert    = 1'b1;
         srma_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
         srma_pkg::ST_DIVIDE:   cmd.div_step  = 1'b1;
         srma_pkg::ST_FINISH:   cmd.out_load  = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ hdl/spike_rejecting_moving_average_core.sv @@
// top level: spike-rejecting moving average of Q16.16 intervals
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_interval_sample
//   rsp     | out       | rsp_valid/rsp_stall | rsp_smoothed_interval, rsp_sample_accepted,
//           |           |                     | rsp_samples_held
//   csr     | in        | csr_valid/csr_ready | csr_reject_threshold
//
// one item passes through the check, evict, insert, divider load, divide and finish states from accept
// to result; the divide state runs the restoring divider that produces one quotient bit a cycle
// reset is synchronous; window contents need no clearing as the fill count guards them
// a result waits in the output register while rsp_stall is high; the next item is taken
// meanwhile and holds in its final state until the output register frees
module spike_rejecting_moving_average_core #(
   parameter int unsigned WINDOW_DEPTH = 50
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [srma_pkg::DATA_W-1:0]      req_interval_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [srma_pkg::DATA_W-1:0]      rsp_smoothed_interval,
   output logic                             rsp_sample_accepted,
   output logic [srma_pkg::HELD_W-1:0]      rsp_samples_held,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srma_pkg::DATA_W-1:0]      csr_reject_threshold
);

   srma_pkg::ctrl_cmd_type  cmd;
   srma_pkg::dp_status_type status;

   // threshold register always takes a write
   assign csr_ready = 1'b1;

   srma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srma_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_interval_sample   (req_interval_sample),
      .csr_write             (csr_valid && csr_ready),
      .csr_reject_threshold  (csr_reject_threshold),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_smoothed_interval (rsp_smoothed_interval),
      .rsp_sample_accepted   (rsp_sample_accepted),
      .rsp_samples_held      (rsp_samples_held)
   );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the spike-rejecting moving average core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DATA_W = srma_pkg::DATA_W;
   localparam int unsigned HELD_W = srma_pkg::HELD_W;
   localparam int unsigned WINDOW_DEPTH = 50;
   localparam int unsigned ITEM_TARGET = 650;
   localparam int unsigned MAX_GAP = 12;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic [DATA_W-1:0] smoothed;
      logic              accepted;
      logic [HELD_W-1:0] held;
   } average_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_interval_sample = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_smoothed_interval;
   logic              rsp_sample_accepted;
   logic [HELD_W-1:0] rsp_samples_held;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [DATA_W-1:0] csr_reject_threshold = '0;

   spike_rejecting_moving_average_core #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_interval_sample  (req_interval_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_smoothed_interval(rsp_smoothed_interval),
      .rsp_sample_accepted  (rsp_sample_accepted),
      .rsp_samples_held     (rsp_samples_held),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_reject_threshold (csr_reject_threshold)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow state of the filter
   logic [DATA_W-1:0] window_shadow [WINDOW_DEPTH];
   int unsigned       fill_shadow = 0;
   int unsigned       slot_shadow = 0;
   logic [63:0]       sum_shadow = '0;
   logic [DATA_W-1:0] average_shadow = '0;
   logic [DATA_W-1:0] threshold_shadow = srma_pkg::THRESHOLD_RESET;

   logic [DATA_W-1:0]  interval_backlog [$];
   average_result_type predicted_averages [$];

   int unsigned queued_count = 0;
   int unsigned checked_count = 0;
   int unsigned accepted_count = 0;
   int unsigned full_window_count = 0;
   int unsigned threshold_writes = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   bit          req_fast = 1'b0;
   bit          rsp_fast = 1'b0;

   // gate the sample on its deviation, update the window and form the new mean
   function automatic average_result_type predict_average(input logic [DATA_W-1:0] sample);
      average_result_type r;
      logic [DATA_W-1:0]  deviation;
      deviation = (sample >= average_shadow) ? sample - average_shadow
                                             : average_shadow - sample;
      r.accepted = deviation < threshold_shadow;
      if (r.accepted) begin
         if (fill_shadow >= WINDOW_DEPTH) begin
            sum_shadow = sum_shadow - window_shadow[slot_shadow];
         end else begin
            fill_shadow++;
         end
         window_shadow[slot_shadow] = sample;
         sum_shadow = sum_shadow + sample;
         slot_shadow = (slot_shadow + 1) % WINDOW_DEPTH;
      end
      average_shadow = (fill_shadow != 0) ? DATA_W'(sum_shadow / fill_shadow) : '0;
      r.smoothed = average_shadow;
      r.held = HELD_W'(fill_shadow);
      return r;
   endfunction

   // random sample within a spread either side of a centre, clipped to the field
   function automatic logic [DATA_W-1:0] near_sample(input logic [DATA_W-1:0] centre,
                                                     input longint unsigned spread);
      longint offset;
      longint value;
      offset = longint'({$urandom, $urandom} % (spread + 1));
      if ($urandom_range(0, 1) == 1) begin
         offset = -offset;
      end
      value = longint'({32'b0, centre}) + offset;
      if (value < 0) begin
         value = 0;
      end else if (value > longint'({32'b0, ALL_ONES})) begin
         value = longint'({32'b0, ALL_ONES});
      end
      return DATA_W'(value);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_averages.push_back(predict_average(req_interval_sample));
            if (predicted_averages[$].accepted) begin
               accepted_count++;
            end
            if (fill_shadow == WINDOW_DEPTH) begin
               full_window_count++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (interval_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_interval_sample <= interval_backlog.pop_front();
               req_gap = req_fast ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      average_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_averages.size() == 0) begin
               $display("%0t: result with none pending: smoothed %h accepted %b held %0d",
                        $time, rsp_smoothed_interval, rsp_sample_accepted, rsp_samples_held);
               error_count++;
            end else begin
               want = predicted_averages.pop_front();
               if (rsp_smoothed_interval !== want.smoothed) begin
                  $display("%0t: smoothed_interval expected %h actual %h",
                           $time, want.smoothed, rsp_smoothed_interval);
                  error_count++;
               end
               if (rsp_sample_accepted !== want.accepted) begin
                  $display("%0t: sample_accepted expected %b actual %b",
                           $time, want.accepted, rsp_sample_accepted);
                  error_count++;
               end
               if (rsp_samples_held !== want.held) begin
                  $display("%0t: samples_held expected %0d actual %0d",
                           $time, want.held, rsp_samples_held);
                  error_count++;
               end
            end
            checked_count++;
            rsp_hold = rsp_fast ? 0 : $urandom_range(0, MAX_GAP);
         end else if (rsp_valid && rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic queue_interval(input logic [DATA_W-1:0] sample);
      interval_backlog.push_back(sample);
      queued_count++;
   endtask

   // wait until every queued item has returned its result
   task automatic settle();
      while (checked_count != queued_count) begin
         @(posedge clock);
      end
   endtask

   task automatic write_threshold(input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_reject_threshold <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      threshold_shadow = value;
      threshold_writes++;
   endtask

   // samples exactly at and just inside the threshold on both sides of the mean
   task automatic probe_edges();
      longint mean;
      longint limit;
      longint value;
      for (int k = 0; k < 4; k++) begin
         mean = longint'({32'b0, average_shadow});
         limit = longint'({32'b0, threshold_shadow});
         case (k)
            0: value = mean + limit;
            1: value = mean + limit - 1;
            2: value = mean - limit;
            default: value = mean - limit + 1;
         endcase
         if (value >= 0 && value <= longint'({32'b0, ALL_ONES})) begin
            queue_interval(DATA_W'(value));
            settle();
         end
      end
   endtask

   initial begin
      logic [DATA_W-1:0] centre;
      longint unsigned   spread;
      int unsigned       phase_items;
      int unsigned       phase_count;
      int unsigned       pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset threshold, extremes of the sample field
      queue_interval('0);
      queue_interval(ALL_ONES);
      queue_interval(32'h0000_FFFF);
      settle();
      probe_edges();

      // zero threshold rejects everything, even a sample equal to the mean
      write_threshold('0);
      queue_interval('0);
      queue_interval(ALL_ONES);
      queue_interval(average_shadow);
      settle();

      // unit threshold accepts only a sample equal to the mean
      write_threshold(32'd1);
      probe_edges();

      // widest threshold, extreme samples
      write_threshold(ALL_ONES);
      queue_interval(ALL_ONES);
      queue_interval('0);
      queue_interval(32'h8000_0000);
      settle();

      // random phases of well-formed streams around the mean, with spikes
      phase_count = 0;
      while (queued_count < ITEM_TARGET) begin
         if (phase_count == 0 || $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0: write_threshold('0);
               1: write_threshold(32'd1);
               2: write_threshold(ALL_ONES);
               3: write_threshold(srma_pkg::THRESHOLD_RESET);
               4, 5: write_threshold($urandom_range(1, 32'h0010_0000));
               6: write_threshold($urandom);
               default: write_threshold($urandom_range(32'h0010_0000, 32'h1000_0000));
            endcase
         end
         pick = $urandom_range(0, 3);
         req_fast = (pick == 1) || (pick == 3);
         rsp_fast = (pick == 2) || (pick == 3);
         phase_items = (threshold_shadow == '0) ? $urandom_range(3, 8) : $urandom_range(20, 70);
         centre = average_shadow;
         spread = {32'b0, threshold_shadow} + {33'b0, threshold_shadow[DATA_W-1:1]};
         for (int n = 0; n < phase_items; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               queue_interval($urandom);
            end else if (pick == 2) begin
               queue_interval(($urandom_range(0, 1) == 1) ? ALL_ONES : '0);
            end else begin
               queue_interval(near_sample(centre, spread));
            end
         end
         settle();
         phase_count++;
      end

      req_fast = 1'b0;
      rsp_fast = 1'b0;
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_averages.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predicted_averages.size());
         error_count += predicted_averages.size();
      end

      $display("%0d intervals checked over %0d threshold writes (%0d random phases)",
               checked_count, threshold_writes, phase_count);
      $display("%0d samples entered the window, %0d results with the window full",
               accepted_count, full_window_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
